/* rtl/dtfd_pkg.sv */
`timescale 1ns / 1ps
package dtfd_pkg;

    localparam int INT_DIGITS = 20;
    localparam int BIN_W      = 64;
    localparam int MANT_W     = 54;
    localparam int PROD_W     = 58;
    localparam int EXP_W      = 12;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAB,
        ST_FMUL,
        ST_FEXT,
        ST_ROT,
        ST_SIGN,
        ST_SKIP,
        ST_INT,
        ST_PT,
        ST_FRAC
    } state_t;

    typedef enum logic [1:0] {
        SEL_MINUS,
        SEL_PLUS,
        SEL_DIGIT,
        SEL_POINT
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      dabble;
        logic      fmul;
        logic      fext;
        logic      push;
        logic      rchk;
        logic      rot;
        logic      shift;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } dtfd_cmd_t;

endpackage

/* rtl/dtfd_ctrl.sv */
`timescale 1ns / 1ps
module dtfd_ctrl #(
    parameter int MAX_FRAC_DIGITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [$clog2(MAX_FRAC_DIGITS + 1) - 1:0]  prec,
    input  logic                                      neg,
    input  logic                                      plus,
    input  logic                                      head_zero,
    input  logic                                      out_free,
    output dtfd_pkg::dtfd_cmd_t                       cmd
);
    localparam int D     = dtfd_pkg::INT_DIGITS + MAX_FRAC_DIGITS;
    localparam int CNT_W = $clog2(D + 65);

    dtfd_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  prec_c;

    assign prec_c = CNT_W'(prec);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtfd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.sel    = dtfd_pkg::SEL_DIGIT;
        case (state_reg)
            dtfd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = dtfd_pkg::ST_DAB;
                end
            end
            dtfd_pkg::ST_DAB: begin
                cmd.dabble = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(dtfd_pkg::BIN_W - 1)) begin
                    cnt_next   = '0;
                    state_next = dtfd_pkg::ST_FMUL;
                end
            end
            dtfd_pkg::ST_FMUL: begin
                cmd.fmul   = 1'b1;
                state_next = dtfd_pkg::ST_FEXT;
            end
            dtfd_pkg::ST_FEXT: begin
                cmd.fext = 1'b1;
                if (cnt_reg == prec_c) begin
                    // extra product decides round half up
                    cmd.rchk   = 1'b1;
                    cnt_next   = '0;
                    state_next = dtfd_pkg::ST_ROT;
                end else begin
                    cmd.push   = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = dtfd_pkg::ST_FMUL;
                end
            end
            dtfd_pkg::ST_ROT: begin
                cmd.rot  = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(D - 1)) begin
                    cnt_next   = CNT_W'(D);
                    state_next = dtfd_pkg::ST_SIGN;
                end
            end
            dtfd_pkg::ST_SIGN: begin
                if (neg || plus) begin
                    if (out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.sel    = neg ? dtfd_pkg::SEL_MINUS : dtfd_pkg::SEL_PLUS;
                        state_next = dtfd_pkg::ST_SKIP;
                    end
                end else begin
                    state_next = dtfd_pkg::ST_SKIP;
                end
            end
            dtfd_pkg::ST_SKIP: begin
                if (head_zero && (cnt_reg > prec_c + CNT_W'(1))) begin
                    cmd.shift = 1'b1;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end else begin
                    state_next = dtfd_pkg::ST_INT;
                end
            end
            dtfd_pkg::ST_INT: begin
                if (out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.shift = 1'b1;
                    cmd.last  = (prec_c == '0) && (cnt_reg == CNT_W'(1));
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == prec_c + CNT_W'(1)) begin
                        state_next = (prec_c != '0) ? dtfd_pkg::ST_PT : dtfd_pkg::ST_IDLE;
                    end
                end
            end
            dtfd_pkg::ST_PT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = dtfd_pkg::SEL_POINT;
                    state_next = dtfd_pkg::ST_FRAC;
                end
            end
            dtfd_pkg::ST_FRAC: begin
                if (out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.shift = 1'b1;
                    cmd.last  = (cnt_reg == CNT_W'(1));
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = dtfd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = dtfd_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

/* rtl/dtfd_dpath.sv */
`timescale 1ns / 1ps
module dtfd_dpath #(
    parameter int MAX_FRAC_DIGITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  dtfd_pkg::dtfd_cmd_t                       cmd,
    input  logic [63:0]                               s_value_bits,
    input  logic [4:0]                                s_frac_digits,
    input  logic                                      s_force_plus,
    output logic [$clog2(MAX_FRAC_DIGITS + 1) - 1:0]  prec,
    output logic                                      neg,
    output logic                                      plus,
    output logic                                      head_zero,
    output logic                                      out_free,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [6:0]                                m_out_char,
    output logic                                      m_last_char,
    output logic                                      m_range_error
);
    localparam int D  = dtfd_pkg::INT_DIGITS + MAX_FRAC_DIGITS;
    localparam int PW = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int MW = dtfd_pkg::MANT_W;
    localparam int QW = dtfd_pkg::PROD_W;
    localparam int EW = dtfd_pkg::EXP_W;

    logic [3:0]           dig_reg [D];
    logic [63:0]          bin_reg;
    logic [MW-1:0]        frm_reg, pm_reg;
    logic signed [EW-1:0] fre_reg, pe_reg;
    logic                 carry_reg;
    logic [PW-1:0]        prec_reg;
    logic                 neg_reg, plus_reg, err_reg;
    logic                 m_valid_reg;
    logic [6:0]           char_reg;
    logic                 last_reg, rerr_reg;

    // ---- decode of the input double
    logic                 sgn, is_nan, is_big, is_zero;
    logic [10:0]          bexp;
    logic [52:0]          mant;
    logic signed [EW-1:0] ex;
    logic [EW-1:0]        s_ld;
    logic [63:0]          ip_ld;
    logic [MW-1:0]        frm_ld;
    logic [PW-1:0]        prec_ld;

    always_comb begin
        sgn     = s_value_bits[63];
        bexp    = s_value_bits[62:52];
        is_zero = (bexp == '0) && (s_value_bits[51:0] == '0);
        is_nan  = (bexp == 11'h7FF) && (s_value_bits[51:0] != '0);
        is_big  = (bexp >= 11'd1087);
        mant    = {(bexp != '0), s_value_bits[51:0]};
        ex      = (bexp == '0) ? -12'sd1074 : ($signed({1'b0, bexp}) - 12'sd1075);
        s_ld    = EW'(-ex);
        ip_ld   = '0;
        frm_ld  = '0;
        if (is_nan) begin
            ip_ld = '0;
        end else if (is_big) begin
            ip_ld = '1;
        end else if (!ex[EW-1]) begin
            ip_ld = 64'(mant) << ex[3:0];
        end else if (s_ld >= EW'(53)) begin
            frm_ld = MW'(mant);
        end else begin
            ip_ld  = 64'(mant >> s_ld[5:0]);
            frm_ld = MW'(mant & ~({53{1'b1}} << s_ld[5:0]));
        end
        if (s_frac_digits > 5'(MAX_FRAC_DIGITS > 31 ? 31 : MAX_FRAC_DIGITS)
            && MAX_FRAC_DIGITS < 31) begin
            prec_ld = PW'(MAX_FRAC_DIGITS);
        end else begin
            prec_ld = PW'(s_frac_digits);
        end
    end

    // ---- fraction times ten, rounded to 53 significant bits
    logic [QW-1:0]        prod, q, rem, half;
    logic [2:0]           k;
    logic                 rup;

    always_comb begin
        prod = QW'({frm_reg, 3'b000}) + QW'({frm_reg, 1'b0});
        if (prod[57])      k = 3'd5;
        else if (prod[56]) k = 3'd4;
        else if (prod[55]) k = 3'd3;
        else if (prod[54]) k = 3'd2;
        else if (prod[53]) k = 3'd1;
        else               k = 3'd0;
        q    = prod >> k;
        rem  = prod & ((QW'(1) << k) - QW'(1));
        half = (QW'(1) << k) >> 1;
        rup  = (k != 3'd0) && ((rem > half) || ((rem == half) && q[0]));
    end

    // ---- integer digit of the product and remaining fraction
    logic [EW-1:0]        s_x;
    logic [3:0]           dint, dsat;
    logic [MW-1:0]        frac_x;

    always_comb begin
        s_x    = EW'(-pe_reg);
        dint   = '0;
        frac_x = '0;
        if (!pe_reg[EW-1]) begin
            dint = 4'(pm_reg << pe_reg[1:0]);
        end else if (s_x >= EW'(QW)) begin
            frac_x = pm_reg;
        end else begin
            dint   = 4'(pm_reg >> s_x[5:0]);
            frac_x = pm_reg & ~({MW{1'b1}} << s_x[5:0]);
        end
        dsat = (dint > 4'd9) ? 4'd9 : dint;
    end

    // ---- digit buffer
    logic [3:0] adj [dtfd_pkg::INT_DIGITS];
    logic [3:0] rdig;

    always_comb begin
        for (int i = 0; i < dtfd_pkg::INT_DIGITS; i++) begin
            adj[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
        if (carry_reg) begin
            rdig = (dig_reg[0] == 4'd9) ? 4'd0 : dig_reg[0] + 4'd1;
        end else begin
            rdig = dig_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg  <= ip_ld;
            frm_reg  <= frm_ld;
            fre_reg  <= ex;
            prec_reg <= prec_ld;
            neg_reg  <= sgn && !is_zero && !is_nan;
            plus_reg <= s_force_plus;
            err_reg  <= is_nan || is_big;
            for (int i = 0; i < D; i++) begin
                dig_reg[i] <= '0;
            end
        end
        if (cmd.dabble) begin
            bin_reg <= {bin_reg[62:0], 1'b0};
            dig_reg[0] <= {adj[0][2:0], bin_reg[63]};
            for (int i = 1; i < dtfd_pkg::INT_DIGITS; i++) begin
                dig_reg[i] <= {adj[i][2:0], adj[i-1][3]};
            end
        end
        if (cmd.fmul) begin
            pm_reg <= MW'(q) + MW'(rup);
            pe_reg <= fre_reg + $signed({9'b0, k});
        end
        if (cmd.fext) begin
            if (dint > 4'd9) begin
                // product hit ten: digit clamps to 9, fraction left is one
                frm_reg <= MW'(1);
                fre_reg <= '0;
            end else begin
                frm_reg <= frac_x;
                fre_reg <= pe_reg;
            end
        end
        if (cmd.rchk) begin
            carry_reg <= (dint >= 4'd5);
        end
        if (cmd.push || cmd.shift) begin
            dig_reg[0] <= cmd.push ? dsat : 4'd0;
            for (int i = 1; i < D; i++) begin
                dig_reg[i] <= dig_reg[i-1];
            end
        end
        if (cmd.rot) begin
            // ripple the round carry from the last digit while rotating
            dig_reg[D-1] <= rdig;
            for (int i = 0; i < D - 1; i++) begin
                dig_reg[i] <= dig_reg[i+1];
            end
            if (carry_reg && dig_reg[0] != 4'd9) begin
                carry_reg <= 1'b0;
            end
        end
        if (cmd.emit) begin
            last_reg <= cmd.last;
            rerr_reg <= err_reg;
            case (cmd.sel)
                dtfd_pkg::SEL_MINUS: char_reg <= dtfd_pkg::CH_MINUS;
                dtfd_pkg::SEL_PLUS:  char_reg <= dtfd_pkg::CH_PLUS;
                dtfd_pkg::SEL_POINT: char_reg <= dtfd_pkg::CH_POINT;
                default:             char_reg <= dtfd_pkg::CH_ZERO | {3'b000, dig_reg[D-1]};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign prec          = prec_reg;
    assign neg           = neg_reg;
    assign plus          = plus_reg;
    assign head_zero     = (dig_reg[D-1] == 4'd0);
    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_out_char    = char_reg;
    assign m_last_char   = last_reg;
    assign m_range_error = rerr_reg;
endmodule

/* rtl/double_to_fixed_decimal_text_core.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake           Payload
// s_       in   s_valid / s_ready   s_value_bits, s_frac_digits, s_force_plus
// m_       out  m_valid / m_ready   m_out_char, m_last_char, m_range_error
//
// A request runs through these steps of digit work, in order (P = capped frac digits):
// the accept, 64 binary-to-BCD steps, a multiply and an extract step for each of the P
// fraction digits and for the rounding digit, and one pass of the digit buffer for the carry.
// Then the sign slot, the scan that suppresses leading zeros, and the characters, each
// sent only when the output register is free.
// aresetn is synchronous, active low; it clears the controller and output valid.
// Output stalls hold the controller; a new request is taken while the last
// character still waits in the output register.
module double_to_fixed_decimal_text_core #(
    parameter int MAX_FRAC_DIGITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    input  logic [4:0]  s_frac_digits,
    input  logic        s_force_plus,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_out_char,
    output logic        m_last_char,
    output logic        m_range_error
);
    localparam int PW = $clog2(MAX_FRAC_DIGITS + 1);

    dtfd_pkg::dtfd_cmd_t cmd;
    logic [PW-1:0]       prec;
    logic                neg, plus, head_zero, out_free;

    dtfd_ctrl #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .prec      (prec),
        .neg       (neg),
        .plus      (plus),
        .head_zero (head_zero),
        .out_free  (out_free),
        .cmd       (cmd)
    );

    dtfd_dpath #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_value_bits  (s_value_bits),
        .s_frac_digits (s_frac_digits),
        .s_force_plus  (s_force_plus),
        .prec          (prec),
        .neg           (neg),
        .plus          (plus),
        .head_zero     (head_zero),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_char   (m_last_char),
        .m_range_error (m_range_error)
    );
endmodule
